[rtl/bdq_pkg.sv]
package bdq_pkg;

  // request codes; codes 6 and 7 are no-ops
  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_FIND       = 3'd4,
    FN_CLEAR      = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

[rtl/bdq_ram.sv]
module bdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/byte_deque_with_search.sv]
// Bounded byte deque with front-to-back linear search, one command at a time.
// Each command is decoded in S_OP; a pop that takes a byte then goes through
// S_POP, a find on a non-empty deque compares entries in S_SCAN, and all then
// pass S_FRONT, S_BACK and S_LAST, which raises done. busy stays high until the
// cycle done is shown; done is one beat the receiver cannot stall.
// Reset (rst, synchronous, active high) empties the deque; store contents stay.
module byte_deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] func,
  input  logic [7:0] value,
  output logic       busy,
  output logic       done,
  output logic [1:0] status,
  output logic [7:0] data,
  output logic [3:0] position,
  output logic [4:0] count,
  output logic [7:0] front_value,
  output logic [7:0] back_value
);

  localparam int AW = $clog2(DEPTH);        // slot index width
  localparam int CW = $clog2(DEPTH + 1);    // entry count width
  localparam logic [AW:0]   DEPTH_SUM  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,      // decode command, do push / clear, start pop or find read
    S_POP,     // popped byte arrives from the RAM
    S_SCAN,    // one compare per cycle against the search key
    S_FRONT,   // read front slot
    S_BACK,    // capture front, read back slot
    S_LAST     // capture back, raise done
  } state_t;

  state_t            state;
  bdq_pkg::func_t    op;
  logic [7:0]        key;
  logic [AW-1:0]     head_index;
  logic [CW-1:0]     entry_count;
  logic [AW-1:0]     idx;          // scan position from the front

  // shared slot unit: (head + offset) wrapped at DEPTH
  logic [AW-1:0]     offset;
  logic [AW:0]       slot_sum;
  logic [AW-1:0]     slot;

  logic [CW-1:0]     cnt_dec;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     head_inc;
  logic              full;
  logic              empty;
  logic              scan_last;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  logic [CW+4:0]     count_ext;
  logic [AW+3:0]     pos_ext;

  assign busy      = (state != S_IDLE);
  assign cnt_dec   = entry_count - CW'(1);
  assign head_dec  = (head_index == '0) ? LAST_SLOT : head_index - AW'(1);
  assign head_inc  = (head_index == LAST_SLOT) ? '0 : head_index + AW'(1);
  assign full      = (entry_count >= DEPTH_CNT);
  assign empty     = (entry_count == '0);
  assign scan_last = ((CW'(idx) + CW'(1)) == entry_count);
  assign count_ext = {5'b0, entry_count};
  assign pos_ext   = {4'b0, idx};

  // offset select for the slot unit, by state and command
  always_comb begin
    offset = '0;
    case (state)
      S_OP: begin
        case (op)
          bdq_pkg::FN_PUSH_BACK: offset = entry_count[AW-1:0];
          bdq_pkg::FN_POP_BACK:  offset = cnt_dec[AW-1:0];
          default:               offset = '0;
        endcase
      end
      S_SCAN:  offset = idx + AW'(1);
      S_BACK:  offset = cnt_dec[AW-1:0];
      default: offset = '0;
    endcase
  end

  assign slot_sum = {1'b0, head_index} + {1'b0, offset};
  assign slot     = (slot_sum >= DEPTH_SUM) ? AW'(slot_sum - DEPTH_SUM) : slot_sum[AW-1:0];

  // write port: pushes only, in the decode cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    if (state == S_OP && !full) begin
      if (op == bdq_pkg::FN_PUSH_FRONT) begin
        ram_we    = 1'b1;
        ram_waddr = head_dec;
      end else if (op == bdq_pkg::FN_PUSH_BACK) begin
        ram_we    = 1'b1;
      end
    end
  end

  assign ram_raddr = slot;

  bdq_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_index  <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op       <= bdq_pkg::func_t'(func);
            key      <= value;
            status   <= bdq_pkg::ST_OK;
            data     <= '0;
            position <= '0;
            idx      <= '0;
            state    <= S_OP;
          end
        end

        S_OP: begin
          state <= S_FRONT;
          case (op)
            bdq_pkg::FN_PUSH_FRONT: begin
              if (full) begin
                status <= bdq_pkg::ST_FULL;
              end else begin
                head_index  <= head_dec;
                entry_count <= entry_count + CW'(1);
              end
            end
            bdq_pkg::FN_PUSH_BACK: begin
              if (full) begin
                status <= bdq_pkg::ST_FULL;
              end else begin
                entry_count <= entry_count + CW'(1);
              end
            end
            bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK: begin
              if (empty) begin
                status <= bdq_pkg::ST_EMPTY;
              end else begin
                state <= S_POP;
              end
            end
            bdq_pkg::FN_FIND: begin
              status <= bdq_pkg::ST_NOT_FOUND;
              if (!empty) begin
                state <= S_SCAN;
              end
            end
            bdq_pkg::FN_CLEAR: begin
              head_index  <= '0;
              entry_count <= '0;
            end
            default: begin
            end
          endcase
        end

        S_POP: begin
          data        <= ram_rdata;
          entry_count <= cnt_dec;
          if (op == bdq_pkg::FN_POP_FRONT) begin
            head_index <= head_inc;
          end
          state <= S_FRONT;
        end

        S_SCAN: begin
          if (ram_rdata == key) begin
            status   <= bdq_pkg::ST_OK;
            data     <= key;
            position <= pos_ext[3:0];
            state    <= S_FRONT;
          end else if (scan_last) begin
            state <= S_FRONT;
          end else begin
            idx <= idx + AW'(1);
          end
        end

        S_FRONT: begin
          state <= S_BACK;
        end

        S_BACK: begin
          front_value <= empty ? 8'd0 : ram_rdata;
          state       <= S_LAST;
        end

        S_LAST: begin
          back_value <= empty ? 8'd0 : ram_rdata;
          count      <= count_ext[4:0];
          done       <= 1'b1;
          state      <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // done is a single-cycle beat
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // occupancy never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst) entry_count <= DEPTH_CNT)
    else $error("entry count beyond depth");

  // a full report only comes from a full store
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == bdq_pkg::ST_FULL) |-> (entry_count == DEPTH_CNT))
    else $error("full status with free slots");

  // an accepted command keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

endmodule

[sim/deque_check_pkg.sv]
`timescale 1ns / 100ps
package deque_check_pkg;
  import bdq_pkg::*;

  localparam int SLOTS = 16;

  // request codes with no operation behind them
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;

  typedef struct {
    status_t    status;
    logic [7:0] data;
    logic [3:0] position;
    logic [4:0] count;
    logic [7:0] front_value;
    logic [7:0] back_value;
  } deque_result_t;

  class deque_scoreboard;
    logic [7:0]    slots [SLOTS];
    int unsigned   head;
    int unsigned   held;
    deque_result_t awaited [$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   op_tally [8];
    int unsigned   full_hits;
    int unsigned   empty_hits;
    int unsigned   find_hits;
    int unsigned   find_misses;

    function new();
      head = 0;
      held = 0;
      mismatches = 0;
      results_seen = 0;
      full_hits = 0;
      empty_hits = 0;
      find_hits = 0;
      find_misses = 0;
      foreach (slots[i]) slots[i] = 8'h00;
      foreach (op_tally[i]) op_tally[i] = 0;
    endfunction

    function logic [7:0] slot_byte(int unsigned ofs);
      return slots[(head + ofs) % SLOTS];
    endfunction

    // a byte currently held, so finds hit more often than chance
    function logic [7:0] held_byte();
      if (held == 0) return 8'($urandom);
      return slot_byte($urandom_range(held - 1));
    endfunction

    // apply one accepted command and queue the result it must produce
    function void note_command(logic [2:0] f, logic [7:0] v);
      deque_result_t r;
      r.status = ST_OK;
      r.data = 8'h00;
      r.position = 4'h0;
      op_tally[f]++;
      case (func_t'(f))
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (held >= SLOTS) begin
            r.status = ST_FULL;
            full_hits++;
          end else if (func_t'(f) == FN_PUSH_FRONT) begin
            head = (head + SLOTS - 1) % SLOTS;
            slots[head] = v;
            held++;
          end else begin
            slots[(head + held) % SLOTS] = v;
            held++;
          end
        end
        FN_POP_FRONT, FN_POP_BACK: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
            empty_hits++;
          end else if (func_t'(f) == FN_POP_FRONT) begin
            r.data = slots[head];
            head = (head + 1) % SLOTS;
            held--;
          end else begin
            r.data = slot_byte(held - 1);
            held--;
          end
        end
        FN_FIND: begin
          r.status = ST_NOT_FOUND;
          for (int unsigned i = 0; i < held; i++) begin
            if (slot_byte(i) == v) begin
              r.status = ST_OK;
              r.data = v;
              r.position = 4'(i);
              break;
            end
          end
          if (r.status == ST_OK) find_hits++;
          else find_misses++;
        end
        FN_CLEAR: begin
          head = 0;
          held = 0;
        end
        default: ;
      endcase
      r.count = 5'(held);
      r.front_value = (held == 0) ? 8'h00 : slots[head];
      r.back_value = (held == 0) ? 8'h00 : slot_byte(held - 1);
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
      end
    endfunction

    function void check_result(deque_result_t got);
      deque_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual status %0d data 0x%0h",
                 $time, got.status, got.data);
        return;
      end
      want = awaited.pop_front();
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("data", want.data, got.data);
      compare_field("position", 8'(want.position), 8'(got.position));
      compare_field("count", 8'(want.count), 8'(got.count));
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("back_value", want.back_value, got.back_value);
    endfunction
  endclass

endpackage

[sim/tb_byte_deque_with_search.sv]
`timescale 1ns / 100ps
module tb_byte_deque_with_search;
  import bdq_pkg::*;
  import deque_check_pkg::*;

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] func = FN_PUSH_FRONT;
  logic [7:0] value = 8'h00;
  logic       busy;
  logic       done;
  logic [1:0] status;
  logic [7:0] data;
  logic [3:0] position;
  logic [4:0] count;
  logic [7:0] front_value;
  logic [7:0] back_value;

  deque_scoreboard board;
  int unsigned     idle_pct = 0;

  byte_deque_with_search uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .value       (value),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .data        (data),
    .position    (position),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; the slowest legal run is well under a fifth of this
  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Results are strobed for one cycle and cannot be held off, so every done
  // beat is taken at the edge that closes it. Sampling right after the edge
  // sees the pre-edge values, which is what the block presented.
  always @(posedge clk) begin : watch
    deque_result_t seen;
    if (!rst && done === 1'b1) begin
      seen.status = status_t'(status);
      seen.data = data;
      seen.position = position;
      seen.count = count;
      seen.front_value = front_value;
      seen.back_value = back_value;
      board.check_result(seen);
    end
  end

  // One command beat. start is raised (or simply left high) and held until an
  // edge finds busy low; that edge takes the beat. Afterwards the sender may
  // drop start for a random gap, with junk on func/value to show it is
  // ignored. With no gap, start stays high so the next command waits on busy.
  task automatic issue(logic [2:0] f, logic [7:0] v);
    start <= 1'b1;
    func <= f;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_command(f, v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      func <= 3'($urandom);
      value <= 8'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Random traffic in fill and drain tides, so the deque sweeps between empty
  // and full and the head pointer wraps both ways. Finds mostly look for a
  // byte that is held; small values recur so duplicates test first-match.
  task automatic random_burst(int unsigned n);
    bit          filling;
    int unsigned roll;
    logic [7:0]  v;
    filling = 1'b1;
    for (int unsigned k = 0; k < n; k++) begin
      if (filling && board.held == SLOTS && $urandom_range(3) == 0) filling = 1'b0;
      if (!filling && board.held == 0 && $urandom_range(3) == 0) filling = 1'b1;
      roll = $urandom_range(99);
      v = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
      if (roll < 1) begin
        issue(FN_CLEAR, v);
      end else if (roll < 3) begin
        issue($urandom_range(1) ? FN_SPARE_A : FN_SPARE_B, v);
      end else if (roll < 23) begin
        issue(FN_FIND, ($urandom_range(3) != 0) ? board.held_byte() : v);
      end else if (roll < 23 + (filling ? 55 : 22)) begin
        issue($urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK, v);
      end else begin
        issue($urandom_range(1) ? FN_POP_FRONT : FN_POP_BACK, v);
      end
    end
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty deque: pops and find on nothing, spare codes as no-ops
    issue(FN_POP_FRONT, 8'h00);
    issue(FN_POP_BACK, 8'hFF);
    issue(FN_FIND, 8'h00);
    issue(FN_SPARE_A, 8'h55);
    issue(FN_SPARE_B, 8'hAA);
    // push front from head 0 wraps the head backwards
    issue(FN_PUSH_FRONT, 8'hFF);
    issue(FN_PUSH_BACK, 8'h00);
    issue(FN_FIND, 8'h00);
    issue(FN_FIND, 8'h7E);
    // fill to the brim from both ends
    for (int i = 0; i < 14; i++)
      issue(i[0] ? FN_PUSH_FRONT : FN_PUSH_BACK, 8'(8'h11 * i));
    issue(FN_PUSH_FRONT, 8'h5A);
    issue(FN_PUSH_BACK, 8'hA5);
    issue(FN_FIND, 8'hCC);
    issue(FN_FIND, 8'h00);
    issue(FN_POP_BACK, 8'h00);
    issue(FN_POP_FRONT, 8'h00);
    issue(FN_CLEAR, 8'hFF);
    issue(FN_POP_BACK, 8'h00);

    idle_pct = 22;
    random_burst(150);
    idle_pct = 81;
    random_burst(150);
    idle_pct = 0;
    random_burst(150);
    start <= 1'b0;

    // drain, then allow a full-length find's worth of cycles for strays
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d results: %0d push, %0d pop, %0d find (%0d hit, %0d miss), %0d clear, %0d no-op",
             board.results_seen,
             board.op_tally[FN_PUSH_FRONT] + board.op_tally[FN_PUSH_BACK],
             board.op_tally[FN_POP_FRONT] + board.op_tally[FN_POP_BACK],
             board.op_tally[FN_FIND], board.find_hits, board.find_misses,
             board.op_tally[FN_CLEAR],
             board.op_tally[FN_SPARE_A] + board.op_tally[FN_SPARE_B]);
    $display("pushes refused as full %0d, pops refused as empty %0d, field mismatches %0d",
             board.full_hits, board.empty_hits, board.mismatches);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
